FILE: hw/rtl/uartrx_pkg.sv
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types, constants and helpers for the UART receive line ring.
// ----------------------------------------------------------------------------
package uartrx_pkg;

    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int LIMIT       = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH);
    localparam int NUM_W = $clog2(LIMIT);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [NUM_W-1:0] t_num;
    typedef logic [7:0]       t_byte;

    localparam logic       OP_RX   = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam t_byte CHAR_CR  = 8'h0D;
    localparam t_byte CHAR_LF  = 8'h0A;
    localparam t_byte CHAR_NUL = 8'h00;

    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_byte wdata;
        t_ptr  raddr;
    } t_ram_req;

    function automatic logic is_line_end(input t_byte b);
        return (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL);
    endfunction

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hw/rtl/uart_rx_line_fifo_core.sv
// ----------------------------------------------------------------------------
// uart_rx_line_fifo_core
// UART receive byte ring with line reads, store held in a synchronous RAM.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  command  | start / busy              | i_opcode, i_rx_byte, error flags
//  result   | o_valid (one-cycle pulse) | o_kind, o_line_byte, o_last,
//           |                           | o_stored_count, o_line_end_event,
//           |                           | o_byte_dropped, o_overflow_flush
//
// Receive item: result in the cycle after acceptance; busy stays low.
// Read item: the first RAM read is issued on acceptance, then one byte per cycle
// over the RAM read port; busy is high meanwhile.
// Read on an empty ring: a single result of kind empty.
// Reset (synchronous, active low) clears pointers, count and sequencer; the
// store itself is not cleared. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module uart_rx_line_fifo_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_opcode,
    input  uartrx_pkg::t_byte       i_rx_byte,
    input  logic                    i_framing_error,
    input  logic                    i_parity_error,
    input  logic                    i_overrun_error,
    output logic                    o_valid,
    output logic [1:0]              o_kind,
    output uartrx_pkg::t_byte       o_line_byte,
    output logic                    o_last,
    output logic [5:0]              o_stored_count,
    output logic                    o_line_end_event,
    output logic                    o_byte_dropped,
    output logic                    o_overflow_flush
);
    import uartrx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic     r_state, n_state;
    t_ptr     r_wp, n_wp;
    t_ptr     r_rp, n_rp;
    t_ptr     r_rdaddr, n_rdaddr;
    t_cnt     r_count, n_count;
    t_num     r_num, n_num;

    logic     r_valid, n_valid;
    logic [1:0] r_kind, n_kind;
    t_byte    r_line_byte, n_line_byte;
    logic     r_last, n_last;
    t_cnt     r_out_count, n_out_count;
    logic     r_ev, n_ev;
    logic     r_drop, n_drop;
    logic     r_ovf, n_ovf;

    t_ram_req ram_req;
    t_byte    ram_rdata;
    logic     accept;
    logic     stop;

    uartrx_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state == ST_READ);
    assign accept = start && !busy;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_rdaddr    = r_rdaddr;
        n_count     = r_count;
        n_num       = r_num;
        n_valid     = 1'b0;
        n_kind      = KIND_ACK;
        n_line_byte = '0;
        n_last      = 1'b1;
        n_out_count = r_count;
        n_ev        = 1'b0;
        n_drop      = 1'b0;
        n_ovf       = 1'b0;
        ram_req     = '{we: 1'b0, waddr: r_wp, wdata: i_rx_byte, raddr: r_rdaddr};
        stop        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_RX) begin
                        n_valid = 1'b1;
                        if (i_framing_error || i_parity_error || i_overrun_error) begin
                            n_drop = 1'b1;
                        end else begin
                            ram_req.we = 1'b1;
                            n_wp       = ptr_inc(r_wp);
                            n_ev       = is_line_end(i_rx_byte);
                            if (r_count == CNT_W'(DEPTH - 1)) begin
                                n_count = '0;
                                n_ovf   = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        n_out_count = n_count;
                    end else if (r_count == '0) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_EMPTY;
                    end else begin
                        ram_req.raddr = r_rp;
                        n_rdaddr      = ptr_inc(r_rp);
                        n_num         = '0;
                        n_state       = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // byte for r_rp is on the RAM output; fetch the next one ahead
                n_rp        = ptr_inc(r_rp);
                n_count     = r_count - 1'b1;
                n_rdaddr    = ptr_inc(r_rdaddr);
                n_num       = r_num + 1'b1;
                stop        = is_line_end(ram_rdata) || (n_count == '0) ||
                              (r_num == NUM_W'(LIMIT - 1));
                n_valid     = 1'b1;
                n_kind      = KIND_BYTE;
                n_line_byte = ram_rdata;
                n_last      = stop;
                n_out_count = n_count;
                if (stop) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_rdaddr <= '0;
            r_count  <= '0;
            r_num    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_rdaddr <= n_rdaddr;
            r_count  <= n_count;
            r_num    <= n_num;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_line_byte <= n_line_byte;
        r_last      <= n_last;
        r_out_count <= n_out_count;
        r_ev        <= n_ev;
        r_drop      <= n_drop;
        r_ovf       <= n_ovf;
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_line_byte      = r_line_byte;
    assign o_last           = r_last;
    assign o_stored_count   = 6'(r_out_count);
    assign o_line_end_event = r_ev;
    assign o_byte_dropped   = r_drop;
    assign o_overflow_flush = r_ovf;

endmodule

FILE: hw/rtl/uartrx_ram.sv
// ----------------------------------------------------------------------------
// uartrx_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uartrx_ram (
    input  logic                 i_clk,
    input  uartrx_pkg::t_ram_req i_req,
    output uartrx_pkg::t_byte    o_rdata
);
    import uartrx_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
